// ===== sv/lbp_pkg.sv =====
// Shared types and constants for the beam-to-point projection block.
package lbp_pkg;

  localparam int AngW = 24;
  localparam int CordW = 33;

  localparam logic signed [CordW-1:0] CordicK = 33'sd652032874;

  typedef enum logic [2:0] {
    REG_ANGLE_START  = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_RANGE_LOW    = 3'd2,
    REG_RANGE_HIGH   = 3'd3,
    REG_MOUNT_HEIGHT = 3'd4,
    REG_MOUNT_SIN    = 3'd5,
    REG_MOUNT_COS    = 3'd6,
    REG_WINDOW_START = 3'd7
  } reg_idx_t;

  // Arc-tangent of 2^-i in units of 2^-24 turn.
  function automatic logic [21:0] atan_turn(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2097152;
      5'd1: v = 22'd1238021;
      5'd2: v = 22'd654136;
      5'd3: v = 22'd332050;
      5'd4: v = 22'd166669;
      5'd5: v = 22'd83416;
      5'd6: v = 22'd41718;
      5'd7: v = 22'd20860;
      5'd8: v = 22'd10430;
      5'd9: v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      5'd21: v = 22'd1;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/lidar_beam_to_point.sv =====
// Top level: pipelined polar-to-Cartesian projection of lidar beams.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | start / busy          | in_range_sample, in_beam_index,
//          |                       | in_rail_position
//  out     | out_strobe            | out_point_x/y/z, out_point_valid,
//          |                       | out_slot_index
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item enters every cycle; busy is always low. The result strobes after
// these registered steps in order: angle multiply and window, angle wrap and
// quadrant, one CORDIC iteration per stage, range products, mount products,
// sums and saturation. Synchronous active-low reset clears the valid bits and
// loads the configuration defaults; data registers are not reset. The receiver
// cannot stall, so the pipeline never holds.
module lidar_beam_to_point import lbp_pkg::*; #(
  parameter int WINDOW_BEAMS  = 400,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_range_sample,
  input  logic [11:0]        in_beam_index,
  input  logic signed [23:0] in_rail_position,
  output logic               out_strobe,
  output logic signed [23:0] out_point_x,
  output logic signed [23:0] out_point_y,
  output logic signed [23:0] out_point_z,
  output logic               out_point_valid,
  output logic [11:0]        out_slot_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int NS = CORDIC_STAGES;

  // Configuration registers
  logic signed [23:0] angle_start_r;
  logic [20:0]        angle_step_r;
  logic [15:0]        range_low_r, range_high_r, mount_height_r;
  logic signed [15:0] mount_sin_r, mount_cos_r;
  logic [11:0]        window_start_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r  <= -24'sd3145728;
      angle_step_r   <= 21'd11651;
      range_low_r    <= 16'd20;
      range_high_r   <= 16'd61440;
      mount_height_r <= 16'd5120;
      mount_sin_r    <= 16'sd23170;
      mount_cos_r    <= 16'sd23170;
      window_start_r <= 12'd340;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ANGLE_START:  angle_start_r  <= cfg_data;
        REG_ANGLE_STEP:   angle_step_r   <= cfg_data[20:0];
        REG_RANGE_LOW:    range_low_r    <= cfg_data[15:0];
        REG_RANGE_HIGH:   range_high_r   <= cfg_data[15:0];
        REG_MOUNT_HEIGHT: mount_height_r <= cfg_data[15:0];
        REG_MOUNT_SIN:    mount_sin_r    <= cfg_data[15:0];
        REG_MOUNT_COS:    mount_cos_r    <= cfg_data[15:0];
        REG_WINDOW_START: window_start_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Stage 1: angle product, window and range checks
  logic               s1_vld_r, s1_keep_r, s1_inr_r;
  logic [23:0]        s1_prod_r;
  logic [11:0]        s1_slot_r;
  logic [15:0]        s1_rng_r;
  logic signed [23:0] s1_rail_r;
  logic [12:0]        slot_full;
  logic [32:0]        prod_full;

  assign slot_full = {1'b0, in_beam_index} - {1'b0, window_start_r};
  assign prod_full = in_beam_index * angle_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_keep_r <= !slot_full[12] && ({1'b0, slot_full[11:0]} < 13'(WINDOW_BEAMS));
    s1_inr_r  <= (in_range_sample > range_low_r) && (in_range_sample < range_high_r);
    s1_prod_r <= prod_full[23:0];
    s1_slot_r <= slot_full[11:0];
    s1_rng_r  <= in_range_sample;
    s1_rail_r <= in_rail_position;
  end

  // Stage 2: wrap angle, split quadrant
  logic               s2_vld_r, s2_keep_r, s2_inr_r;
  logic [1:0]         s2_quad_r;
  logic [11:0]        s2_slot_r;
  logic [15:0]        s2_rng_r;
  logic signed [23:0] s2_rail_r;
  logic [23:0]        ang;

  assign ang = angle_start_r + s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // CORDIC pipeline registers, index 0 is the start vector
  logic signed [CordW-1:0] cx_r [0:NS];
  logic signed [CordW-1:0] cy_r [0:NS];
  logic signed [23:0]      cz_r [0:NS];
  logic                    cv_r [0:NS];
  logic                    ck_r [0:NS];
  logic                    ci_r [0:NS];
  logic [1:0]              cq_r [0:NS];
  logic [11:0]             cs_r [0:NS];
  logic [15:0]             cr_r [0:NS];
  logic signed [23:0]      cl_r [0:NS];

  always_ff @(posedge clk) begin
    s2_keep_r <= s1_keep_r;
    s2_inr_r  <= s1_inr_r;
    s2_quad_r <= ang[23:22];
    s2_slot_r <= s1_slot_r;
    s2_rng_r  <= s1_rng_r;
    s2_rail_r <= s1_rail_r;
  end

  assign cx_r[0] = CordicK;
  assign cy_r[0] = '0;
  assign cv_r[0] = s2_vld_r;
  assign ck_r[0] = s2_keep_r;
  assign ci_r[0] = s2_inr_r;
  assign cq_r[0] = s2_quad_r;
  assign cs_r[0] = s2_slot_r;
  assign cr_r[0] = s2_rng_r;
  assign cl_r[0] = s2_rail_r;

  logic [21:0] s2_z_r;
  always_ff @(posedge clk) begin
    s2_z_r <= ang[21:0];
  end
  assign cz_r[0] = {2'b00, s2_z_r};

  // Advance one rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CordW-1:0] dx, dy;
    logic signed [23:0]      at;
    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign at = $signed({2'b00, atan_turn(5'(i))});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!cz_r[i][23]) begin
        cx_r[i+1] <= cx_r[i] - dx;
        cy_r[i+1] <= cy_r[i] + dy;
        cz_r[i+1] <= cz_r[i] - at;
      end else begin
        cx_r[i+1] <= cx_r[i] + dx;
        cy_r[i+1] <= cy_r[i] - dy;
        cz_r[i+1] <= cz_r[i] + at;
      end
      ck_r[i+1] <= ck_r[i];
      ci_r[i+1] <= ci_r[i];
      cq_r[i+1] <= cq_r[i];
      cs_r[i+1] <= cs_r[i];
      cr_r[i+1] <= cr_r[i];
      cl_r[i+1] <= cl_r[i];
    end
  end

  // Quadrant map
  logic signed [CordW-1:0] qc, qs;
  always_comb begin
    case (cq_r[NS])
      2'd0: begin qc = cx_r[NS];  qs = cy_r[NS];  end
      2'd1: begin qc = -cy_r[NS]; qs = cx_r[NS];  end
      2'd2: begin qc = -cx_r[NS]; qs = -cy_r[NS]; end
      default: begin qc = cy_r[NS]; qs = -cx_r[NS]; end
    endcase
  end

  // Stage 3: range products, rounded from Q30
  logic               s3_vld_r, s3_keep_r, s3_inr_r;
  logic [11:0]        s3_slot_r;
  logic signed [23:0] s3_rail_r;
  logic signed [23:0] s3_rc_r, s3_xy_r;
  logic signed [50:0] pc, ps;

  assign pc = $signed({1'b0, cr_r[NS]}) * qc + (51'sd1 <<< 29);
  assign ps = $signed({1'b0, cr_r[NS]}) * qs + (51'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= cv_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    s3_keep_r <= ck_r[NS];
    s3_inr_r  <= ci_r[NS];
    s3_slot_r <= cs_r[NS];
    s3_rail_r <= cl_r[NS];
    s3_rc_r   <= 24'(pc >>> 30);
    s3_xy_r   <= 24'(ps >>> 30);
  end

  // Stage 4: mount products, rounded from Q15
  logic               s4_vld_r, s4_keep_r, s4_inr_r;
  logic [11:0]        s4_slot_r;
  logic signed [23:0] s4_rail_r, s4_mx_r, s4_my_r;
  logic signed [24:0] s4_z_r;
  logic signed [40:0] ms, mc;

  assign ms = s3_xy_r * mount_sin_r + 41'sd16384;
  assign mc = s3_xy_r * mount_cos_r + 41'sd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_keep_r <= s3_keep_r;
    s4_inr_r  <= s3_inr_r;
    s4_slot_r <= s3_slot_r;
    s4_rail_r <= s3_rail_r;
    s4_mx_r   <= 24'(ms >>> 15);
    s4_my_r   <= 24'(mc >>> 15);
    s4_z_r    <= $signed({9'd0, mount_height_r}) - 25'(s3_rc_r);
  end

  // Stage 5: sums, saturation, drop out-of-window beams
  logic               out_strobe_r, out_valid_r;
  logic signed [23:0] out_x_r, out_y_r, out_z_r;
  logic [11:0]        out_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s4_vld_r && s4_keep_r;
    end
  end

  always_ff @(posedge clk) begin
    out_valid_r <= s4_inr_r;
    out_slot_r  <= s4_slot_r;
    if (s4_inr_r) begin
      out_x_r <= sat24(48'(s4_rail_r) + 48'(s4_mx_r));
      out_y_r <= sat24(-48'(s4_my_r));
      out_z_r <= sat24(48'(s4_z_r));
    end else begin
      out_x_r <= '0;
      out_y_r <= '0;
      out_z_r <= '0;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_z     = out_z_r;
  assign out_point_valid = out_valid_r;
  assign out_slot_index  = out_slot_r;

endmodule

// ===== sv/lbp_checker.sv =====
// Port-level checker for the beam-to-point projection block, with its bind.
module lbp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [23:0] out_point_x,
  input logic signed [23:0] out_point_y,
  input logic signed [23:0] out_point_z,
  input logic               out_point_valid,
  input logic               cfg_ready
);

  // Invalid points carry zero coordinates
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_point_valid |->
      out_point_x == 0 && out_point_y == 0 && out_point_z == 0)
    else $error("invalid point not zero");

  // No strobe out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  // Input is never refused
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Configuration is always taken
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg not ready");

endmodule

bind lidar_beam_to_point lbp_checker u_lbp_checker (.*);
